// ===== hw/rtl/kvt_pkg.sv =====
// Shared types and constants of the key/value table.
package kvt_pkg;

	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	// One memory word: valid bit, key, value.
	localparam int WORD_W = 1 + KEY_W + VAL_W;

	localparam logic [VAL_W-1:0] ABSENT_VALUE = '1;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic free;
	} scan_flags_t;

endpackage

// ===== hw/rtl/kvt_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/kvt_scan.sv =====
// Scan tracker: finds the entry holding a key and the lowest free entry.
module kvt_scan #(
	parameter int IW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kvt_pkg::scan_ctl_t       ctl,
	input  logic [IW-1:0]            index,
	input  logic [kvt_pkg::KEY_W-1:0] key,
	input  logic [kvt_pkg::WORD_W-1:0] word,
	output kvt_pkg::scan_flags_t     flags,
	output logic [IW-1:0]            hit_idx,
	output logic [IW-1:0]            free_idx,
	output logic [kvt_pkg::VAL_W-1:0] hit_value
);
	import kvt_pkg::*;

	logic             word_valid;
	logic [KEY_W-1:0] word_key;
	logic [VAL_W-1:0] word_value;
	logic             hit_q;
	logic             free_q;

	assign word_valid = word[WORD_W-1];
	assign word_key   = word[VAL_W +: KEY_W];
	assign word_value = word[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.sample) begin
			if (word_valid && word_key == key && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!word_valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// Index and value registers only load on the first match or first free slot.
	always_ff @(posedge clk) begin
		if (ctl.sample && !ctl.clear) begin
			if (word_valid && word_key == key && !hit_q) begin
				hit_idx   <= index;
				hit_value <= word_value;
			end
			if (!word_valid && !free_q) begin
				free_idx <= index;
			end
		end
	end

	assign flags.hit  = hit_q;
	assign flags.free = free_q;

endmodule

// ===== hw/rtl/key_value_table.sv =====
// Top level of the key/value table: sequencer, scan tracker and entry memory.
//
// An associative table of up to ENTRIES key/value pairs. A word is accepted on
// a rising edge with start high and busy low; operation selects put, get or
// remove, lookup_key names the key and new_value carries the value of a put.
// Each word yields exactly one result, shown for one cycle with done high:
// read_value, found and status. The receiver cannot stall the block.
//
// Every operation reads all ENTRIES memory words in order through the single
// memory port, one per cycle, then waits for the last read in S_DRAIN and
// writes back in S_WRITE where a put or remove needs it; the next word is
// taken in S_IDLE after that, and done rises in the cycle in which busy falls.
//
// After reset the block clears every memory word, one per cycle, and holds
// busy high until the last one is cleared, before the first word is taken.
module key_value_table #(
	parameter int ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic signed [kvt_pkg::KEY_W-1:0] lookup_key,
	input  logic signed [kvt_pkg::VAL_W-1:0] new_value,
	output logic                          done,
	output logic signed [kvt_pkg::VAL_W-1:0] read_value,
	output logic                          found,
	output logic [1:0]                    status
);
	import kvt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	state_t            state_q, state_d;
	logic [IW-1:0]     addr_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic              sample_s1;
	logic [IW-1:0]     idx_s1;

	logic              ram_we;
	logic [IW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	scan_ctl_t         scan_ctl;
	scan_flags_t       flags;
	logic [IW-1:0]     hit_idx;
	logic [IW-1:0]     free_idx;
	logic [VAL_W-1:0]  hit_value;

	logic [VAL_W-1:0]  res_value;
	logic              res_found;
	logic [1:0]        res_status;
	logic              accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	kvt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign scan_ctl.clear  = accept;
	assign scan_ctl.sample = sample_s1;

	kvt_scan #(
		.IW(IW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.index    (idx_s1),
		.key      (key_q),
		.word     (ram_rdata),
		.flags    (flags),
		.hit_idx  (hit_idx),
		.free_idx (free_idx),
		.hit_value(hit_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			addr_q    <= '0;
			sample_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_d;
			sample_s1 <= (state_q == S_SCAN);
			done      <= (state_q == S_WRITE);
			if (accept) begin
				addr_q <= '0;
			end else if (state_q == S_CLEAR || state_q == S_SCAN) begin
				addr_q <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			op_q  <= operation;
			key_q <= lookup_key;
			val_q <= new_value;
		end
		if (state_q == S_WRITE) begin
			read_value <= res_value;
			found      <= res_found;
			status     <= res_status;
		end
	end

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_addr   = addr_q;
		ram_wdata  = '0;
		res_value  = ABSENT_VALUE;
		res_found  = 1'b0;
		res_status = STAT_OK;

		unique case (op_q)
			OP_PUT: begin
				res_found = flags.hit;
				if (!flags.hit && !flags.free) begin
					res_status = STAT_FULL;
				end
			end
			OP_GET: begin
				res_found = flags.hit;
				if (flags.hit) begin
					res_value = hit_value;
				end else begin
					res_status = STAT_MISSING;
				end
			end
			OP_REMOVE: begin
				res_found = flags.hit;
				if (!flags.hit) begin
					res_status = STAT_MISSING;
				end
			end
			default: begin
			end
		endcase

		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (addr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (addr_q == LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				state_d = S_IDLE;
				unique case (op_q)
					OP_PUT: begin
						ram_wdata = {1'b1, key_q, val_q};
						if (flags.hit) begin
							ram_we   = 1'b1;
							ram_addr = hit_idx;
						end else if (flags.free) begin
							ram_we   = 1'b1;
							ram_addr = free_idx;
						end
					end
					OP_REMOVE: begin
						// A freed entry is written back with its valid bit low.
						ram_we   = flags.hit;
						ram_addr = hit_idx;
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== tb/tb_key_value_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the key/value table: directed and random put, get and remove words.
module tb_key_value_table;
	import kvt_pkg::*;

	localparam int ENTRIES = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int KEY_POOL = 96;
	localparam int RANDOM_WORDS = 700;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {
		MODE_FILL,
		MODE_MIXED,
		MODE_EMPTY
	} mix_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             wait_idle;
	} word_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             found;
		logic [1:0]       stat;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] operation = '0;
	logic signed [KEY_W-1:0] lookup_key = '0;
	logic signed [VAL_W-1:0] new_value = '0;
	logic busy;
	logic done;
	logic signed [VAL_W-1:0] read_value;
	logic found;
	logic [1:0] status;

	// Shadow copy of the table contents.
	logic [KEY_W-1:0] held_keys [ENTRIES];
	logic [VAL_W-1:0] held_vals [ENTRIES];
	logic             held_valid [ENTRIES];

	logic [KEY_W-1:0] key_pool [KEY_POOL];

	word_t    pending_q [$];
	outcome_t expected_q [$];
	word_t    cur_word;
	int       n_accepted = 0;
	int       results_seen = 0;
	int       total_words = 0;
	int       errors = 0;
	int       cycles = 0;

	key_value_table #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.lookup_key(lookup_key),
		.new_value(new_value),
		.done(done),
		.read_value(read_value),
		.found(found),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one word to the shadow table and returns the result it must produce.
	function automatic outcome_t apply_word(word_t w);
		outcome_t r;
		int hit;
		int slot;
		r.value = ABSENT_VALUE;
		r.found = 1'b0;
		r.stat = STAT_OK;
		hit = -1;
		slot = -1;
		// Walking downward leaves the lowest matching and lowest free entries.
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (held_valid[i] && held_keys[i] == w.key)
				hit = i;
			if (!held_valid[i])
				slot = i;
		end
		case (w.op)
		OP_PUT: begin
			if (hit >= 0) begin
				held_vals[hit] = w.value;
				r.found = 1'b1;
			end else if (slot >= 0) begin
				held_keys[slot] = w.key;
				held_vals[slot] = w.value;
				held_valid[slot] = 1'b1;
			end else begin
				r.stat = STAT_FULL;
			end
		end
		OP_GET: begin
			if (hit >= 0) begin
				r.value = held_vals[hit];
				r.found = 1'b1;
			end else begin
				r.stat = STAT_MISSING;
			end
		end
		OP_REMOVE: begin
			if (hit >= 0) begin
				held_valid[hit] = 1'b0;
				r.found = 1'b1;
			end else begin
				r.stat = STAT_MISSING;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic word_t make_word(logic [1:0] op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value, logic wait_idle);
		word_t w;
		w.op = op;
		w.key = key;
		w.value = value;
		w.wait_idle = wait_idle;
		return w;
	endfunction

	// Appends a word at the tail of the pending queue.
	function automatic void add_word(word_t w);
		pending_q.insert(pending_q.size(), w);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 95)
			return key_pool[$urandom_range(KEY_POOL - 1)];
		return $urandom;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(39))
		0: return '0;
		1: return 32'h7fff_ffff;
		2: return 32'h8000_0000;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	// Sender holds back a word with a chance of 13 percent, then 79, then never.
	function automatic int sender_idle_pct(int accepted);
		if (accepted < 260)
			return 13;
		if (accepted < 520)
			return 79;
		return 0;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : sender
		logic  go;
		word_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			operation <= '0;
			lookup_key <= '0;
			new_value <= '0;
			for (int i = 0; i < ENTRIES; i++)
				held_valid[i] = 1'b0;
		end else begin
			go = start;
			if (start && !busy) begin
				expected_q.insert(expected_q.size(), apply_word(cur_word));
				n_accepted++;
				go = 1'b0;
			end
			if (!go && pending_q.size() > 0) begin
				nxt = pending_q[0];
				// A result strobed at this edge has not reached results_seen yet.
				if (nxt.wait_idle && n_accepted != results_seen + done) begin
				end else if ($urandom_range(99) >= sender_idle_pct(n_accepted)) begin
					void'(pending_q.pop_front());
					cur_word <= nxt;
					operation <= nxt.op;
					lookup_key <= nxt.key;
					new_value <= nxt.value;
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	always @(posedge clk) begin : receiver
		outcome_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: read_value %h found %b status %0d",
					$time, read_value, found, status);
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("read_value", want.value, read_value);
				check_field("found", 32'(want.found), 32'(found));
				check_field("status", 32'(want.stat), 32'(status));
			end
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_key_value_table: errors");
			$finish;
		end
	end

	initial begin
		mix_t mode;
		int   run_len;
		int   put_lim;
		int   get_lim;
		int   rem_lim;
		int   roll;
		logic [1:0] op;

		key_pool[0] = 32'h7fff_ffff;
		key_pool[1] = 32'h8000_0000;
		key_pool[2] = '0;
		key_pool[3] = '1;
		for (int i = 4; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		// Directed words on an empty table: misses, extremes, overwrite,
		// unused code, removal and refill of a freed entry.
		add_word(make_word(OP_GET, '0, '0, 1'b0));
		add_word(make_word(OP_REMOVE, '0, '0, 1'b0));
		add_word(make_word(OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
		add_word(make_word(OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
		add_word(make_word(OP_PUT, '0, '0, 1'b0));
		add_word(make_word(OP_PUT, '1, '1, 1'b0));
		add_word(make_word(OP_GET, 32'h7fff_ffff, '1, 1'b0));
		add_word(make_word(OP_GET, 32'h8000_0000, '0, 1'b0));
		add_word(make_word(OP_GET, '1, 32'h5555_aaaa, 1'b0));
		add_word(make_word(OP_PUT, 32'h7fff_ffff, 32'h1234_5678, 1'b1));
		add_word(make_word(OP_GET, 32'h7fff_ffff, '0, 1'b0));
		add_word(make_word(OP_UNUSED, '0, 32'd5, 1'b0));
		add_word(make_word(OP_GET, '0, '0, 1'b0));
		add_word(make_word(OP_REMOVE, 32'h8000_0000, '1, 1'b0));
		add_word(make_word(OP_GET, 32'h8000_0000, '0, 1'b0));
		add_word(make_word(OP_REMOVE, 32'h8000_0000, '0, 1'b0));
		add_word(make_word(OP_UNUSED, 32'h8000_0000, '1, 1'b0));
		add_word(make_word(OP_PUT, 32'h8000_0000, 32'hdead_beef, 1'b0));
		add_word(make_word(OP_GET, 32'h8000_0000, '0, 1'b0));
		add_word(make_word(OP_GET, '1, '0, 1'b0));

		// Random runs: filling runs push past capacity, emptying runs free
		// entries again, mixed runs mostly hit held keys.
		mode = MODE_FILL;
		while (pending_q.size() < 20 + RANDOM_WORDS) begin
			run_len = $urandom_range(30, 90);
			case (mode)
			MODE_FILL: begin
				put_lim = 80; get_lim = 95; rem_lim = 98;
			end
			MODE_MIXED: begin
				put_lim = 35; get_lim = 75; rem_lim = 97;
			end
			default: begin
				put_lim = 15; get_lim = 40; rem_lim = 98;
			end
			endcase
			for (int n = 0; n < run_len; n++) begin
				roll = $urandom_range(99);
				if (roll < put_lim)
					op = OP_PUT;
				else if (roll < get_lim)
					op = OP_GET;
				else if (roll < rem_lim)
					op = OP_REMOVE;
				else
					op = OP_UNUSED;
				add_word(make_word(op, pick_key(), pick_value(),
					$urandom_range(59) == 0));
			end
			roll = $urandom_range(99);
			mode = roll < 40 ? MODE_FILL : (roll < 75 ? MODE_MIXED : MODE_EMPTY);
		end
		total_words = pending_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (results_seen == total_words);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_key_value_table: clean");
		else
			$display("tb_key_value_table: errors");
		$finish;
	end

endmodule
